// ----- rtl/lzwve_pkg.sv -----
// Shared constants and types for the variable-width LZW encoder.
package lzwve_pkg;

  // Default sizing of the code space and the hashed dictionary.
  localparam int DefCodeBits   = 15;
  localparam int DefDictEntries = 35023;

  // Reserved codes and the initial code-space settings.
  localparam logic [8:0]  END_CODE    = 9'd256;
  localparam logic [8:0]  WIDEN_CODE  = 9'd257;
  localparam logic [8:0]  CLEAR_CODE  = 9'd258;
  localparam logic [8:0]  FIRST_FREE  = 9'd259;
  localparam logic [4:0]  INIT_WIDTH  = 5'd9;
  localparam logic [8:0]  INIT_THRESH = 9'd511;

  // Output byte budget after reset.
  localparam logic [20:0] CAP_RESET = 21'd1048576;

  // Width of the generation tag kept with each dictionary entry.
  localparam int EpochBits = 8;

  // Sequencer states, one-hot.
  typedef enum logic [9:0] {
    ST_SWEEP   = 10'b00_0000_0001,
    ST_IDLE    = 10'b00_0000_0010,
    ST_RESTART = 10'b00_0000_0100,
    ST_MOD     = 10'b00_0000_1000,
    ST_READ    = 10'b00_0001_0000,
    ST_CHECK   = 10'b00_0010_0000,
    ST_EMIT    = 10'b00_0100_0000,
    ST_LASTCHK = 10'b00_1000_0000,
    ST_PAD     = 10'b01_0000_0000,
    ST_FIN     = 10'b10_0000_0000
  } state_t;

  // Which code the bit packer is currently shifting out.
  typedef enum logic [3:0] {
    PH_MISS_STR = 4'b0001,
    PH_POST     = 4'b0010,
    PH_LAST_STR = 4'b0100,
    PH_LAST_END = 4'b1000
  } phase_t;

  // Code that follows the string code after a miss.
  typedef enum logic [1:0] {
    POST_NONE  = 2'd0,
    POST_BUMP  = 2'd1,
    POST_FLUSH = 2'd2
  } post_t;

endpackage

// ----- rtl/lzw_variable_width_encoder.sv -----
// Top level of the variable-width LZW encoder: sequencer, dictionary memory, bit packer.
//
// Usage: one uncompressed byte enters per in_ beat (in_valid high, in_stall low),
// with in_last_byte marking the final byte of a stream. Each packed output byte
// leaves as an out_ beat with out_last_out set on the final byte caused by that
// input and out_status set when the byte budget (cfg_output_capacity) was exceeded;
// such a byte reads as zero. Users write it through cfg_wr_en while idle (unenforced).
// Flow: a later input of a stream has its hash reduced below the table size, then
// probes the single dictionary read port until a free slot, a match or the last try;
// codes shift out one bit per cycle (9 to CODE_BITS bits per code) unless a finished
// byte waits for the output. in_stall stays high for the whole of an item.
// Dictionary restarts bump a generation tag; every 255th restart, and once after
// reset, a clearing pass over all DICT_ENTRIES entries rewrites the tags first.
// Reset (rst_n low, synchronous) empties the output register and starts that pass.
// When the receiver stalls, the output register holds its beat and the packer
// waits at the next completed byte; no result is dropped.
module lzw_variable_width_encoder
  import lzwve_pkg::*;
#(
  parameter int CODE_BITS    = DefCodeBits,
  parameter int DICT_ENTRIES = DefDictEntries
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [20:0] cfg_output_capacity,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_last_out,
  output logic        out_status
);

  localparam int CB = CODE_BITS;
  localparam int IW = $clog2(DICT_ENTRIES);
  localparam int TW = $clog2(DICT_ENTRIES + 1);
  localparam int HW = (CB > IW) ? CB : IW;
  localparam int NW = CB + 1;
  localparam int MW = EpochBits + 2 * CB + 8;
  localparam logic [HW:0] DICT_H = (HW + 1)'(DICT_ENTRIES);
  localparam logic [IW:0] DICT_I = (IW + 1)'(DICT_ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(DICT_ENTRIES - 1);
  localparam logic [TW-1:0] LAST_TRY = TW'(DICT_ENTRIES - 1);

  // Dictionary memory: tag, code, parent, char.
  logic [MW-1:0] mem [DICT_ENTRIES];
  logic [MW-1:0] rd_q;
  logic          we;
  logic [IW-1:0] waddr;
  logic [MW-1:0] wdata;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;
  post_t  post_r, post_nxt;

  logic [20:0]          cap_r, cap_nxt;
  logic [7:0]           ch_r, ch_nxt;
  logic                 last_r, last_nxt;
  logic                 act_r, act_nxt;
  logic                 started_r, started_nxt;
  logic [CB-1:0]        string_r, string_nxt;
  logic [HW-1:0]        hash_r, hash_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;
  logic [IW-1:0]        step_r, step_nxt;
  logic [TW-1:0]        tries_r, tries_nxt;
  logic [IW-1:0]        sw_r, sw_nxt;
  logic [EpochBits-1:0] epoch_r, epoch_nxt;
  logic [NW-1:0]        nf_r, nf_nxt;
  logic [NW-1:0]        thr_r, thr_nxt;
  logic [4:0]           width_r, width_nxt;
  logic [CB-1:0]        code_r, code_nxt;
  logic [4:0]           bits_r, bits_nxt;
  logic [7:0]           rack_r, rack_nxt;
  logic [7:0]           pos_r, pos_nxt;
  logic [20:0]          bytes_r, bytes_nxt;
  logic                 held_v_r, held_v_nxt;
  logic [7:0]           held_byte_r, held_byte_nxt;
  logic                 held_st_r, held_st_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [7:0]           out_byte_r, out_byte_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_st_r, out_st_nxt;

  logic          out_free;
  logic          can_put;
  logic          do_put;
  logic [7:0]    put_val;
  logic          send;
  logic          send_last;
  logic          cload;
  logic [CB-1:0] cload_val;
  logic [7:0]    rack_v;
  logic          hit_used;
  logic          hit_match;
  logic [CB-1:0] hash_v;
  logic [NW-1:0] nf_inc;

  assign out_free = !out_valid_r || !out_stall;
  assign can_put  = !held_v_r || out_free;
  assign hit_used  = rd_q[MW-1 -: EpochBits] == epoch_r;
  assign hit_match = (rd_q[CB+7 -: CB] == string_r) && (rd_q[7:0] == ch_r);
  assign hash_v = ({{(CB-8){1'b0}}, in_data_byte} << (CB - 8)) ^ string_r;
  assign nf_inc = nf_r + NW'(1);
  assign rack_v = code_r[CB-1] ? (rack_r | pos_r) : rack_r;

  // Dictionary memory ports.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[idx_r];
  end

  // Sequencer and datapath next-state logic.
  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    post_nxt      = post_r;
    cap_nxt       = cfg_wr_en ? cfg_output_capacity : cap_r;
    ch_nxt        = ch_r;
    last_nxt      = last_r;
    act_nxt       = act_r;
    started_nxt   = started_r;
    string_nxt    = string_r;
    hash_nxt      = hash_r;
    idx_nxt       = idx_r;
    step_nxt      = step_r;
    tries_nxt     = tries_r;
    sw_nxt        = sw_r;
    epoch_nxt     = epoch_r;
    nf_nxt        = nf_r;
    thr_nxt       = thr_r;
    width_nxt     = width_r;
    code_nxt      = code_r;
    bits_nxt      = bits_r;
    rack_nxt      = rack_r;
    pos_nxt       = pos_r;
    bytes_nxt     = bytes_r;
    held_v_nxt    = held_v_r;
    held_byte_nxt = held_byte_r;
    held_st_nxt   = held_st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_st_nxt    = out_st_r;
    we            = 1'b0;
    waddr         = idx_r;
    wdata         = '0;
    do_put        = 1'b0;
    put_val       = rack_r;
    send          = 1'b0;
    send_last     = 1'b0;
    cload         = 1'b0;
    cload_val     = string_r;

    case (state_r)
      // Clearing pass: tag every entry with the unused generation.
      ST_SWEEP: begin
        we    = 1'b1;
        waddr = sw_r;
        sw_nxt = sw_r + IW'(1);
        if (sw_r == LAST_IDX) begin
          epoch_nxt = EpochBits'(1);
          state_nxt = act_r ? ST_LASTCHK : ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          ch_nxt   = in_data_byte;
          last_nxt = in_last_byte;
          act_nxt  = 1'b1;
          if (!started_r) begin
            rack_nxt    = '0;
            pos_nxt     = 8'h80;
            bytes_nxt   = '0;
            string_nxt  = {{(CB-8){1'b0}}, in_data_byte};
            started_nxt = 1'b1;
            state_nxt   = ST_RESTART;
          end else begin
            hash_nxt  = HW'(hash_v);
            state_nxt = ST_MOD;
          end
        end
      end

      // Dictionary restart: new generation and initial code space.
      ST_RESTART: begin
        nf_nxt    = NW'(FIRST_FREE);
        width_nxt = INIT_WIDTH;
        thr_nxt   = NW'(INIT_THRESH);
        if (epoch_r == '1) begin
          sw_nxt    = '0;
          state_nxt = ST_SWEEP;
        end else begin
          epoch_nxt = epoch_r + EpochBits'(1);
          state_nxt = ST_LASTCHK;
        end
      end

      // Reduce the hash below the table size by repeated subtraction.
      ST_MOD: begin
        if ({1'b0, hash_r} >= DICT_H) begin
          hash_nxt = hash_r - DICT_H[HW-1:0];
        end else begin
          idx_nxt   = IW'(hash_r);
          step_nxt  = (hash_r == '0) ? IW'(1) : IW'(DICT_I - (IW + 1)'(hash_r));
          tries_nxt = '0;
          state_nxt = ST_READ;
        end
      end

      ST_READ: begin
        state_nxt = ST_CHECK;
      end

      // Probe result: free slot, match, last try (emit and flush), or step to the next slot.
      ST_CHECK: begin
        if (!hit_used) begin
          we     = 1'b1;
          wdata  = {epoch_r, nf_r[CB-1:0], string_r, ch_r};
          nf_nxt = nf_inc;
          if (nf_inc[CB]) begin
            post_nxt = POST_FLUSH;
          end else if (nf_inc > thr_r) begin
            post_nxt = POST_BUMP;
          end else begin
            post_nxt = POST_NONE;
          end
          cload     = 1'b1;
          phase_nxt = PH_MISS_STR;
          state_nxt = ST_EMIT;
        end else if (hit_match) begin
          string_nxt = rd_q[2*CB+7 -: CB];
          state_nxt  = ST_LASTCHK;
        end else if (tries_r == LAST_TRY) begin
          post_nxt  = POST_FLUSH;
          cload     = 1'b1;
          phase_nxt = PH_MISS_STR;
          state_nxt = ST_EMIT;
        end else begin
          tries_nxt = tries_r + TW'(1);
          if (idx_r >= step_r) begin
            idx_nxt = idx_r - step_r;
          end else begin
            idx_nxt = IW'({1'b0, idx_r} + DICT_I - {1'b0, step_r});
          end
          state_nxt = ST_READ;
        end
      end

      // Shift one code bit into the rack per cycle, waiting while a finished byte cannot be put.
      ST_EMIT: begin
        if (!(pos_r[0] && !can_put)) begin
          code_nxt = code_r << 1;
          bits_nxt = bits_r - 5'd1;
          if (pos_r[0]) begin
            do_put   = 1'b1;
            put_val  = rack_v;
            rack_nxt = '0;
            pos_nxt  = 8'h80;
          end else begin
            rack_nxt = rack_v;
            pos_nxt  = pos_r >> 1;
          end
          if (bits_r == 5'd1) begin
            case (phase_r)
              PH_MISS_STR: begin
                string_nxt = {{(CB-8){1'b0}}, ch_r};
                if (post_r == POST_FLUSH) begin
                  cload     = 1'b1;
                  cload_val = CB'(CLEAR_CODE);
                  phase_nxt = PH_POST;
                end else if (post_r == POST_BUMP) begin
                  cload     = 1'b1;
                  cload_val = CB'(WIDEN_CODE);
                  phase_nxt = PH_POST;
                end else begin
                  state_nxt = ST_LASTCHK;
                end
              end
              PH_POST: begin
                if (post_r == POST_FLUSH) begin
                  state_nxt = ST_RESTART;
                end else begin
                  width_nxt = width_r + 5'd1;
                  thr_nxt   = {thr_r[NW-2:0], 1'b1};
                  state_nxt = ST_LASTCHK;
                end
              end
              PH_LAST_STR: begin
                cload     = 1'b1;
                cload_val = CB'(END_CODE);
                phase_nxt = PH_LAST_END;
              end
              PH_LAST_END: begin
                // A pad byte follows unless this bit completed a byte.
                state_nxt = pos_r[0] ? ST_FIN : ST_PAD;
              end
              default: begin
                state_nxt = ST_FIN;
              end
            endcase
          end
        end
      end

      ST_LASTCHK: begin
        if (last_r) begin
          cload     = 1'b1;
          phase_nxt = PH_LAST_STR;
          state_nxt = ST_EMIT;
        end else begin
          state_nxt = ST_FIN;
        end
      end

      // Zero-padded final byte of a stream.
      ST_PAD: begin
        if (can_put) begin
          do_put    = 1'b1;
          rack_nxt  = '0;
          pos_nxt   = 8'h80;
          state_nxt = ST_FIN;
        end
      end

      // Release the held byte as the item's final beat.
      ST_FIN: begin
        if (!held_v_r || out_free) begin
          if (held_v_r) begin
            send       = 1'b1;
            send_last  = 1'b1;
            held_v_nxt = 1'b0;
          end
          if (last_r) begin
            started_nxt = 1'b0;
            string_nxt  = '0;
          end
          act_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Load a code into the packer, left aligned.
    if (cload) begin
      code_nxt = cload_val << (5'(CB) - width_r);
      bits_nxt = width_r;
    end

    // A completed byte pushes the previous one out and takes its place.
    if (do_put) begin
      if (held_v_r) begin
        send = 1'b1;
      end
      held_v_nxt = 1'b1;
      if (bytes_r < cap_r) begin
        held_byte_nxt = put_val;
        held_st_nxt   = 1'b0;
        bytes_nxt     = bytes_r + 21'd1;
      end else begin
        held_byte_nxt = '0;
        held_st_nxt   = 1'b1;
      end
    end

    // Output register load.
    if (send) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = held_byte_r;
      out_st_nxt    = held_st_r;
      out_last_nxt  = send_last;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_SWEEP;
      cap_r       <= CAP_RESET;
      act_r       <= 1'b0;
      started_r   <= 1'b0;
      string_r    <= '0;
      sw_r        <= '0;
      epoch_r     <= '0;
      nf_r        <= NW'(FIRST_FREE);
      thr_r       <= NW'(INIT_THRESH);
      width_r     <= INIT_WIDTH;
      rack_r      <= '0;
      pos_r       <= 8'h80;
      bytes_r     <= '0;
      held_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cap_r       <= cap_nxt;
      act_r       <= act_nxt;
      started_r   <= started_nxt;
      string_r    <= string_nxt;
      sw_r        <= sw_nxt;
      epoch_r     <= epoch_nxt;
      nf_r        <= nf_nxt;
      thr_r       <= thr_nxt;
      width_r     <= width_nxt;
      rack_r      <= rack_nxt;
      pos_r       <= pos_nxt;
      bytes_r     <= bytes_nxt;
      held_v_r    <= held_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    phase_r     <= phase_nxt;
    post_r      <= post_nxt;
    ch_r        <= ch_nxt;
    last_r      <= last_nxt;
    hash_r      <= hash_nxt;
    idx_r       <= idx_nxt;
    step_r      <= step_nxt;
    tries_r     <= tries_nxt;
    code_r      <= code_nxt;
    bits_r      <= bits_nxt;
    held_byte_r <= held_byte_nxt;
    held_st_r   <= held_st_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    out_st_r    <= out_st_nxt;
  end

  assign in_stall     = state_r != ST_IDLE;
  assign out_valid    = out_valid_r;
  assign out_byte     = out_byte_r;
  assign out_last_out = out_last_r;
  assign out_status   = out_st_r;

endmodule
